/* src/vertex_normal_weld_assert.svh */
// Assertion macros used by the vertex normal weld RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef VERTEX_NORMAL_WELD_ASSERT_SVH
`define VERTEX_NORMAL_WELD_ASSERT_SVH

`define VNW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define VNW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/vnw_pkg.sv */
// Package for the vertex normal weld: sizes, item structs and the
// controller to datapath command and status structs. No dependencies.
package vnw_pkg;

  localparam int MAX_VERTS = 64;
  localparam int AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int SW = $clog2(MAX_VERTS + 2);

  localparam int SUMW  = 23;
  localparam int SQW   = 44;
  localparam int VW    = 62;
  localparam int ROOTW = 31;
  localparam int NUMW  = 46;
  localparam int ENTW  = 144;

  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;

  typedef struct packed {
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [31:0]        pos_z;
    logic signed [15:0] norm_in_x;
    logic signed [15:0] norm_in_y;
    logic signed [15:0] norm_in_z;
    logic               last_in;
  } in_t;

  typedef struct packed {
    logic signed [15:0] norm_out_x;
    logic signed [15:0] norm_out_y;
    logic signed [15:0] norm_out_z;
    logic               was_changed;
    logic [6:0]         total_changed;
    logic               overflowed;
    logic               last_out;
  } out_t;

  typedef struct packed {
    logic          load;
    logic [AW-1:0] rd_addr;
    logic          latch_a;
    logic          issue;
    logic          sq_mul;
    logic          sq_first;
    logic          sq_acc;
    logic [1:0]    sel;
    logic          sqrt_init;
    logic          sqrt_step;
    logic          div_load;
    logic          div_step;
    logic          div_store;
    logic          emit;
    logic          final_out;
  } cmd_t;

  typedef struct packed {
    logic [CW-1:0] n;
    logic          skip;
  } sts_t;

endpackage

/* src/vnw_ctrl.sv */
// Controller state machine of the vertex normal weld.
// Depends on vnw_pkg and vertex_normal_weld_assert.svh.
module vnw_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          last_in,
  input  vnw_pkg::sts_t sts,
  output logic          busy,
  output vnw_pkg::cmd_t cmd
);
  import vnw_pkg::*;

`include "vertex_normal_weld_assert.svh"

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_RDA   = 10'b0000000010,
    ST_LATA  = 10'b0000000100,
    ST_SCAN  = 10'b0000001000,
    ST_SQ    = 10'b0000010000,
    ST_CHK   = 10'b0000100000,
    ST_SQRT  = 10'b0001000000,
    ST_DIVLD = 10'b0010000000,
    ST_DIV   = 10'b0100000000,
    ST_DIVST = 10'b1000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] a_r, a_nxt;
  logic [SW-1:0] k_r, k_nxt;
  logic [1:0]    c_r, c_nxt;
  logic          emit_r, emit_nxt;
  logic          is_final;
  logic          k_in;

  assign is_final = (CW'(a_r) + CW'(1)) == sts.n;
  assign k_in     = k_r < SW'(sts.n);
  assign busy     = (state_r != ST_IDLE) || emit_r;

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    k_nxt     = k_r;
    c_nxt     = c_r;
    emit_nxt  = 1'b0;
    cmd       = '0;
    cmd.rd_addr = a_r;
    cmd.sel     = c_r;
    if (emit_r) begin
      cmd.emit      = 1'b1;
      cmd.final_out = is_final;
      if (!is_final) begin
        a_nxt = a_r + AW'(1);
      end else begin
        a_nxt = '0;
      end
    end
    case (state_r)
      ST_IDLE: begin
        if (start && !emit_r) begin
          cmd.load = 1'b1;
          if (last_in) begin
            state_nxt = ST_RDA;
          end
        end else if (emit_r && !is_final) begin
          state_nxt = ST_RDA;
        end
      end
      ST_RDA: begin
        state_nxt = ST_LATA;
      end
      ST_LATA: begin
        cmd.latch_a = 1'b1;
        k_nxt       = '0;
        state_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.rd_addr = k_r[AW-1:0];
        cmd.issue   = k_in && (k_r[AW-1:0] != a_r);
        if (k_r == SW'(sts.n) + SW'(1)) begin
          k_nxt     = '0;
          state_nxt = ST_SQ;
        end else begin
          k_nxt = k_r + SW'(1);
        end
      end
      ST_SQ: begin
        cmd.sel      = k_r[1:0];
        cmd.sq_mul   = k_r < SW'(3);
        cmd.sq_acc   = k_r != '0;
        cmd.sq_first = k_r == SW'(1);
        if (k_r == SW'(3)) begin
          state_nxt = ST_CHK;
        end else begin
          k_nxt = k_r + SW'(1);
        end
      end
      ST_CHK: begin
        k_nxt = '0;
        if (sts.skip) begin
          emit_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.sqrt_init = 1'b1;
          state_nxt     = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (k_r == SW'(ROOTW - 1)) begin
          c_nxt     = SEL_X;
          state_nxt = ST_DIVLD;
        end else begin
          k_nxt = k_r + SW'(1);
        end
      end
      ST_DIVLD: begin
        cmd.div_load = 1'b1;
        k_nxt        = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (k_r == SW'(NUMW - 1)) begin
          state_nxt = ST_DIVST;
        end else begin
          k_nxt = k_r + SW'(1);
        end
      end
      ST_DIVST: begin
        cmd.div_store = 1'b1;
        if (c_r == SEL_Z) begin
          emit_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          c_nxt     = c_r + 2'd1;
          state_nxt = ST_DIVLD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      a_r     <= '0;
      k_r     <= '0;
      c_r     <= SEL_X;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_r     <= a_nxt;
      k_r     <= k_nxt;
      c_r     <= c_nxt;
      emit_r  <= emit_nxt;
    end
  end

  `VNW_ASSERT_NEXT(a_last_starts, start && !busy && last_in, busy, "last item did not start compute")
  `VNW_ASSERT_NEXT(a_emit_single, emit_r, !emit_r, "result emitted twice in a row")
  `VNW_ASSERT_SAME(a_scan_bound, state_r == ST_SCAN, k_r <= SW'(sts.n) + SW'(1), "scan overran")
  `VNW_ASSERT_SAME(a_no_load_busy, cmd.load, !emit_r && state_r == ST_IDLE, "load while busy")

endmodule

/* src/vnw_dp.sv */
// Datapath of the vertex normal weld: vertex memory, pairwise compare,
// square sum, bit-serial square root and divider. Depends on vnw_pkg.
module vnw_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  vnw_pkg::cmd_t      cmd,
  input  vnw_pkg::in_t       in_data,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_data,
  output vnw_pkg::sts_t      sts,
  output vnw_pkg::out_t      out_data,
  output logic               out_strobe
);
  import vnw_pkg::*;

  logic [ENTW-1:0]    mem [MAX_VERTS];
  logic [ENTW-1:0]    rd_q;
  logic [ENTW-1:0]    mine_r;
  logic signed [15:0] cfg_r;
  logic [CW-1:0]      count_r;
  logic               ovf_r;

  logic               iss1_r, v2_r;
  logic signed [31:0] p0_r, p1_r, p2_r;
  logic [47:0]        bn_r;
  logic signed [SUMW-1:0] sx_r, sy_r, sz_r;
  logic               taken_r;
  logic [SQW-1:0]     sq_r, s_acc_r;

  logic [VW-1:0]      v_r;
  logic [ROOTW-1:0]   root_r;
  logic [ROOTW:0]     rem_r;
  logic [NUMW-1:0]    num_r, dq_r;
  logic [ROOTW-1:0]   drem_r;
  logic               neg_r;
  logic signed [15:0] o_r [3];
  logic [6:0]         chg_cnt_r;
  out_t               out_r;
  logic               strobe_r;

  logic signed [15:0] mx, my, mz;
  logic signed [15:0] bx, by, bz;
  logic signed [33:0] dot, thr;
  logic signed [SUMW-1:0] ssel;
  logic [SUMW-2:0]    mag;
  logic [SQW-1:0]     sq_full;
  logic [ROOTW+3:0]   rem_t, trial;
  logic [ROOTW:0]     drem_t;
  logic [15:0]        qsat;
  logic               chg;
  logic signed [15:0] ox, oy, oz;

  assign mx = mine_r[15:0];
  assign my = mine_r[31:16];
  assign mz = mine_r[47:32];
  assign bx = bn_r[15:0];
  assign by = bn_r[31:16];
  assign bz = bn_r[47:32];

  assign sts.n    = count_r;
  assign sts.skip = !taken_r || (s_acc_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load && (count_r < CW'(MAX_VERTS))) begin
      mem[count_r[AW-1:0]] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z,
                               in_data.norm_in_z, in_data.norm_in_y, in_data.norm_in_x};
    end
    rd_q <= mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= '0;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      iss1_r    <= 1'b0;
      v2_r      <= 1'b0;
      chg_cnt_r <= '0;
      strobe_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
      if (cmd.load) begin
        if (count_r < CW'(MAX_VERTS)) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      iss1_r   <= cmd.issue;
      v2_r     <= iss1_r && (rd_q[143:48] == mine_r[143:48]);
      strobe_r <= cmd.emit;
      if (cmd.emit) begin
        if (cmd.final_out) begin
          count_r   <= '0;
          ovf_r     <= 1'b0;
          chg_cnt_r <= '0;
        end else begin
          chg_cnt_r <= chg_cnt_r + 7'(chg);
        end
      end
    end
  end

  assign dot = 34'(p0_r) + 34'(p1_r) + 34'(p2_r);
  assign thr = {{3{cfg_r[15]}}, cfg_r, 15'b0};

  always_comb begin
    case (cmd.sel)
      SEL_X:   ssel = sx_r;
      SEL_Y:   ssel = sy_r;
      default: ssel = sz_r;
    endcase
  end
  assign mag = ssel[SUMW-1] ? (SUMW-1)'(-ssel) : ssel[SUMW-2:0];
  assign sq_full = SQW'(mag) * SQW'(mag);

  assign rem_t  = {1'b0, rem_r, v_r[VW-1:VW-2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign drem_t = {drem_r, num_r[NUMW-1]};

  always_comb begin
    if (neg_r) begin
      qsat = (dq_r > NUMW'(32768)) ? 16'h8000 : 16'(-dq_r[15:0]);
    end else begin
      qsat = (dq_r > NUMW'(32767)) ? 16'h7fff : dq_r[15:0];
    end
  end

  always_comb begin
    if (sts.skip) begin
      ox  = mx;
      oy  = my;
      oz  = mz;
      chg = 1'b0;
    end else begin
      ox  = o_r[0];
      oy  = o_r[1];
      oz  = o_r[2];
      chg = (o_r[0] != mx) || (o_r[1] != my) || (o_r[2] != mz);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_a) begin
      mine_r  <= rd_q;
      sx_r    <= SUMW'(signed'(rd_q[15:0]));
      sy_r    <= SUMW'(signed'(rd_q[31:16]));
      sz_r    <= SUMW'(signed'(rd_q[47:32]));
      taken_r <= 1'b0;
    end else if (v2_r && (dot >= thr)) begin
      sx_r    <= sx_r + SUMW'(bx);
      sy_r    <= sy_r + SUMW'(by);
      sz_r    <= sz_r + SUMW'(bz);
      taken_r <= 1'b1;
    end
    p0_r <= 32'(mx) * 32'(signed'(rd_q[15:0]));
    p1_r <= 32'(my) * 32'(signed'(rd_q[31:16]));
    p2_r <= 32'(mz) * 32'(signed'(rd_q[47:32]));
    bn_r <= rd_q[47:0];

    if (cmd.sq_mul) begin
      sq_r <= sq_full;
    end
    if (cmd.sq_acc) begin
      s_acc_r <= cmd.sq_first ? sq_r : s_acc_r + sq_r;
    end

    if (cmd.sqrt_init) begin
      v_r    <= {s_acc_r, 18'b0};
      root_r <= '0;
      rem_r  <= '0;
    end else if (cmd.sqrt_step) begin
      v_r <= {v_r[VW-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_r  <= (ROOTW+1)'(rem_t - trial);
        root_r <= {root_r[ROOTW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_t[ROOTW:0];
        root_r <= {root_r[ROOTW-2:0], 1'b0};
      end
    end

    if (cmd.div_load) begin
      num_r  <= {mag, 24'b0} + NUMW'(root_r >> 1);
      dq_r   <= '0;
      drem_r <= '0;
      neg_r  <= ssel[SUMW-1];
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUMW-2:0], 1'b0};
      if (drem_t >= {1'b0, root_r}) begin
        drem_r <= ROOTW'(drem_t - {1'b0, root_r});
        dq_r   <= {dq_r[NUMW-2:0], 1'b1};
      end else begin
        drem_r <= drem_t[ROOTW-1:0];
        dq_r   <= {dq_r[NUMW-2:0], 1'b0};
      end
    end
    if (cmd.div_store) begin
      o_r[cmd.sel] <= qsat;
    end

    if (cmd.emit) begin
      out_r.norm_out_x    <= ox;
      out_r.norm_out_y    <= oy;
      out_r.norm_out_z    <= oz;
      out_r.was_changed   <= chg;
      out_r.total_changed <= cmd.final_out ? chg_cnt_r + 7'(chg) : 7'd0;
      out_r.overflowed    <= ovf_r;
      out_r.last_out      <= cmd.final_out;
    end
  end

  assign out_data   = out_r;
  assign out_strobe = strobe_r;

endmodule

/* src/vertex_normal_weld.sv */
// Vertex normal weld: loads up to MAX_VERTS vertices, one item per cycle while busy is low, and
// after the last one emits one smoothed normal per vertex in load order.
// Per result: a pass over the vertex memory read port, a 31-step square root and three divides,
// one per axis; the root and divides are skipped when a vertex keeps its normal.
// busy is high from the last item until its final result is issued; out_strobe marks
// each result for one cycle and the receiver cannot stall. Sync active-low reset clears control.
module vertex_normal_weld (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  vnw_pkg::in_t       in_data,
  output logic               out_strobe,
  output vnw_pkg::out_t      out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] cfg_data
);
  import vnw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  vnw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .last_in (in_data.last_in),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  vnw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_data    (in_data),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .sts        (sts),
    .out_data   (out_data),
    .out_strobe (out_strobe)
  );

endmodule
